/* rtl/core/aes128_round_operations_unit_macros.svh */
// Assertion macros shared by the round operations unit.
`ifndef AES128_ROUND_OPERATIONS_UNIT_MACROS_SVH
`define AES128_ROUND_OPERATIONS_UNIT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/aes_rou_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES round operations package
// Command codes, controller commands and the byte tables and field math.
// ----------------------------------------------------------------------------
package aes_rou_pkg;

	localparam logic [2:0] CMD_EXPAND  = 3'd0;
	localparam logic [2:0] CMD_ADDKEY  = 3'd1;
	localparam logic [2:0] CMD_SUB     = 3'd2;
	localparam logic [2:0] CMD_INVSUB  = 3'd3;
	localparam logic [2:0] CMD_SHIFT   = 3'd4;
	localparam logic [2:0] CMD_INVSHIFT = 3'd5;
	localparam logic [2:0] CMD_MIX     = 3'd6;
	localparam logic [2:0] CMD_INVMIX  = 3'd7;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;      // capture operand and run a block transform
		logic key_load;  // capture the key and store round key 0
		logic key_step;  // compute and store the next round key
		logic key_done;  // mark the schedule complete
	} ctl_t;

	localparam logic [7:0] SBOX [256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

	localparam logic [7:0] SBOX_REV [256] = '{
	8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
	8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
	8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
	8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
	8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
	8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
	8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
	8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
	8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
	8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
	8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
	8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
	8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
	8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
	8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
	8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

	localparam logic [7:0] POLY_RED = 8'h1b;
	localparam logic [7:0] TOP_BIT  = 8'h80;

	// Multiply by x in GF(2^8).
	function automatic logic [7:0] xtime(input logic [7:0] v);
		logic [7:0] r;
		r = {v[6:0], 1'b0};
		if ((v & TOP_BIT) != 8'h00) begin
			r = r ^ POLY_RED;
		end
		return r;
	endfunction

endpackage

/* rtl/core/aes_rou_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES round operations controller
// Accepts commands and sequences the ROUNDS key schedule rounds (ten by default).
// ----------------------------------------------------------------------------
`include "aes128_round_operations_unit_macros.svh"
module aes_rou_ctrl #(
	parameter int ROUNDS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [2:0]            command,
	output logic                  busy,
	output logic                  done,
	output aes_rou_pkg::ctl_t     ctl
);

	localparam int CW = $clog2(ROUNDS + 1);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_KEY  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic          accept;

	assign accept = start && !busy;
	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

	// Command decode toward the datapath.
	always_comb begin
		ctl.load     = accept && (command != aes_rou_pkg::CMD_EXPAND);
		ctl.key_load = accept && (command == aes_rou_pkg::CMD_EXPAND);
		ctl.key_step = (state_q == ST_KEY);
		ctl.key_done = (state_q == ST_FIN);
	end

	// State sequence: one schedule round per cycle, then report.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= ctl.load || ctl.key_done;
			unique case (state_q)
				ST_IDLE: begin
					if (ctl.key_load) begin
						state_q <= ST_KEY;
						cnt_q   <= CW'(1);
					end
				end
				ST_KEY: begin
					if (cnt_q == CW'(ROUNDS)) begin
						state_q <= ST_FIN;
					end
					cnt_q <= cnt_q + CW'(1);
				end
				ST_FIN: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_IMPL(a_no_accept_busy, clk, arst_n, !(busy && (ctl.load || ctl.key_load)))
	`ASSERT_NEXT(a_fin_done, clk, arst_n, state_q == ST_FIN, done_q && state_q == ST_IDLE)
	`ASSERT_IMPL(a_cnt_range, clk, arst_n, cnt_q <= CW'(ROUNDS + 1))

endmodule

/* rtl/core/aes_rou_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES round operations datapath
// Block transforms, key schedule round and round key store.
// ----------------------------------------------------------------------------
module aes_rou_dp #(
	parameter int ROUNDS = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  aes_rou_pkg::ctl_t ctl,
	input  logic [2:0]        command,
	input  logic [63:0]       data_hi,
	input  logic [63:0]       data_lo,
	input  logic [3:0]        round_index,
	output logic [63:0]       result_hi,
	output logic [63:0]       result_lo,
	output logic              key_valid
);

	localparam int RW = $clog2(ROUNDS + 1);

	logic [63:0]    store_hi_q [ROUNDS+1];
	logic [63:0]    store_lo_q [ROUNDS+1];
	logic           loaded_q;
	logic [127:0]   key_q;
	logic [7:0]     rc_q;
	logic [RW-1:0]  wr_q;
	logic [127:0]   res_q;
	logic [7:0]     m [16];
	logic [7:0]     o [16];
	logic [7:0]     k [16];
	logic [7:0]     nk [16];
	logic [7:0]     t [4];
	logic [127:0]   nk_flat;
	logic [127:0]   res_d;
	logic [RW-1:0]  ridx;

	// Byte view of operand and current key, byte 0 in the top bits.
	always_comb begin
		for (int n = 0; n < 16; n++) begin
			m[n] = (n < 8) ? data_hi[56-8*(n%8) +: 8] : data_lo[56-8*(n%8) +: 8];
			k[n] = key_q[120-8*n +: 8];
		end
	end

	// Saturate the round index.
	assign ridx = (round_index > 4'(ROUNDS)) ? RW'(ROUNDS) : RW'(round_index);

	// One key schedule round.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			t[i] = aes_rou_pkg::SBOX[k[((i + 1) % 4) * 4 + 3]];
		end
		t[0] = t[0] ^ rc_q;
		for (int i = 0; i < 4; i++) begin
			nk[i*4]     = k[i*4] ^ t[i];
			nk[i*4 + 1] = k[i*4 + 1] ^ nk[i*4];
			nk[i*4 + 2] = k[i*4 + 2] ^ nk[i*4 + 1];
			nk[i*4 + 3] = k[i*4 + 3] ^ nk[i*4 + 2];
		end
		for (int n = 0; n < 16; n++) begin
			nk_flat[120-8*n +: 8] = nk[n];
		end
	end

	// Block transforms selected by the command.
	always_comb begin
		logic [7:0] b2, b4, b8, s;
		b2 = 8'h00;
		b4 = 8'h00;
		b8 = 8'h00;
		s  = 8'h00;
		for (int n = 0; n < 16; n++) o[n] = m[n];
		unique case (command)
			aes_rou_pkg::CMD_SUB: begin
				for (int n = 0; n < 16; n++) o[n] = aes_rou_pkg::SBOX[m[n]];
			end
			aes_rou_pkg::CMD_INVSUB: begin
				for (int n = 0; n < 16; n++) o[n] = aes_rou_pkg::SBOX_REV[m[n]];
			end
			aes_rou_pkg::CMD_SHIFT: begin
				for (int i = 0; i < 4; i++)
					for (int j = 0; j < 4; j++) o[i*4+j] = m[i*4 + ((j + i) % 4)];
			end
			aes_rou_pkg::CMD_INVSHIFT: begin
				for (int i = 0; i < 4; i++)
					for (int j = 0; j < 4; j++) o[i*4+j] = m[i*4 + ((j + 4 - i) % 4)];
			end
			aes_rou_pkg::CMD_MIX: begin
				for (int i = 0; i < 4; i++)
					for (int j = 0; j < 4; j++) begin
						s = 8'h00;
						for (int c = 0; c < 4; c++) begin
							b2 = aes_rou_pkg::xtime(m[c*4+j]);
							unique case ((c - i + 4) % 4)
								0: s = s ^ b2;
								1: s = s ^ b2 ^ m[c*4+j];
								default: s = s ^ m[c*4+j];
							endcase
						end
						o[i*4+j] = s;
					end
			end
			aes_rou_pkg::CMD_INVMIX: begin
				for (int i = 0; i < 4; i++)
					for (int j = 0; j < 4; j++) begin
						s = 8'h00;
						for (int c = 0; c < 4; c++) begin
							b2 = aes_rou_pkg::xtime(m[c*4+j]);
							b4 = aes_rou_pkg::xtime(b2);
							b8 = aes_rou_pkg::xtime(b4);
							unique case ((c - i + 4) % 4)
								0: s = s ^ b8 ^ b4 ^ b2;
								1: s = s ^ b8 ^ b2 ^ m[c*4+j];
								2: s = s ^ b8 ^ b4 ^ m[c*4+j];
								default: s = s ^ b8 ^ m[c*4+j];
							endcase
						end
						o[i*4+j] = s;
					end
			end
			default: ;
		endcase
		for (int n = 0; n < 16; n++) res_d[120-8*n +: 8] = o[n];
		if (command == aes_rou_pkg::CMD_ADDKEY && loaded_q) begin
			res_d = {data_hi ^ store_hi_q[ridx], data_lo ^ store_lo_q[ridx]};
		end
	end

	// Round key store, written one key per cycle during the schedule, and result register.
	always_ff @(posedge clk) begin
		if (ctl.key_load) begin
			store_hi_q[0] <= data_hi;
			store_lo_q[0] <= data_lo;
			key_q <= {data_hi, data_lo};
			rc_q  <= 8'h01;
			wr_q  <= RW'(1);
		end else if (ctl.key_step) begin
			store_hi_q[wr_q] <= nk_flat[127:64];
			store_lo_q[wr_q] <= nk_flat[63:0];
			key_q <= nk_flat;
			rc_q  <= aes_rou_pkg::xtime(rc_q);
			wr_q  <= wr_q + RW'(1);
		end
		if (ctl.load) begin
			res_q <= res_d;
		end else if (ctl.key_done) begin
			res_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= 1'b0;
		end else if (ctl.key_done) begin
			loaded_q <= 1'b1;
		end
	end

	assign result_hi = res_q[127:64];
	assign result_lo = res_q[63:0];
	assign key_valid = loaded_q;

endmodule

/* rtl/core/aes128_round_operations_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 round operations unit
// Runs one AES round primitive or the key schedule per command.
// ----------------------------------------------------------------------------
// Channel   Handshake      Fields
// command   start / busy   command, data_hi, data_lo, round_index
// result    done strobe    result_hi, result_lo, key_valid
//
// A block transform registers its result in the cycle after the transfer; a new
// command may follow in the next cycle. Expand key runs the schedule rounds one
// at a time through the single key round unit, with busy high. Reset clears the
// controller and the key valid flag; the receiver cannot stall, so each done
// strobe lasts one cycle.
// ----------------------------------------------------------------------------
module aes128_round_operations_unit #(
	parameter int ROUNDS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic [2:0]  command,
	input  logic [63:0] data_hi,
	input  logic [63:0] data_lo,
	input  logic [3:0]  round_index,
	output logic [63:0] result_hi,
	output logic [63:0] result_lo,
	output logic        key_valid
);

	aes_rou_pkg::ctl_t ctl;

	aes_rou_ctrl #(.ROUNDS(ROUNDS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .command(command),
		.busy(busy), .done(done), .ctl(ctl)
	);

	aes_rou_dp #(.ROUNDS(ROUNDS)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .command(command),
		.data_hi(data_hi), .data_lo(data_lo), .round_index(round_index),
		.result_hi(result_hi), .result_lo(result_lo), .key_valid(key_valid)
	);

endmodule
